// ----- src/fct_pkg.sv -----
// Shared types and constants of the frustum cull test unit.
package fct_pkg;

    localparam int PLANE_W   = 64;  // one packed plane register
    localparam int CFG_COUNT = 6;   // plane registers: left, right, top, bottom, far, near
    localparam int CFG_IDX_W = 3;   // register index width
    localparam int COORD_W   = 16;  // Q11.4 coordinate
    localparam int RADIUS_W  = 15;  // Q11.4 radius, unsigned
    localparam int NORM_FRAC = 14;  // fraction bits of a Q1.14 normal
    localparam int PROD_W    = 2 * COORD_W;          // one normal by coordinate product
    localparam int LIMIT_W   = RADIUS_W + NORM_FRAC + 1;
    localparam int DIST_W    = PROD_W + 2;           // sum of three products and the offset

    // Stream payload layout
    localparam int S_TDATA_W = 112;  // six coordinates and the radius, padded to bytes
    localparam int M_TDATA_W = 8;    // inside flag, padded to a byte

    // Register order (the packed plane register holds d in the top bits)
    typedef struct packed {
        logic signed [COORD_W-1:0] d;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nx;
    } t_plane;

    typedef struct packed {
        logic signed [COORD_W-1:0] z;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] x;
    } t_vec3;

    // Item as seen by the plane evaluators in the first stage
    typedef struct packed {
        logic  box;
        t_vec3 lo;
        t_vec3 hi;
    } t_item;

endpackage

// ----- src/fct_cfg_regs.sv -----
// Plane register file written through the configuration port.
module fct_cfg_regs #(
    parameter int NUM_STORED = 6
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [fct_pkg::PLANE_W-1:0]            i_cfg_data,
    output fct_pkg::t_plane [NUM_STORED-1:0]       o_planes
);
    import fct_pkg::*;

    t_plane [NUM_STORED-1:0] r_planes;

    // Indices without a stored plane are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_planes <= '0;
        end else if (i_cfg_we) begin
            for (int k = 0; k < NUM_STORED; k++) begin
                if (i_cfg_idx == CFG_IDX_W'(k)) begin
                    r_planes[k] <= t_plane'(i_cfg_data);
                end
            end
        end
    end

    assign o_planes = r_planes;

endmodule

// ----- src/fct_plane_eval.sv -----
// Distance test of one item against one plane: registered products, then sum and compare.
module fct_plane_eval (
    input  logic                                   i_clk,
    input  logic                                   i_en,
    input  fct_pkg::t_plane                        i_plane,
    input  fct_pkg::t_item                         i_item,
    input  logic signed [fct_pkg::LIMIT_W-1:0]     i_limit,
    output logic                                   o_reject
);
    import fct_pkg::*;

    logic                      pos_x, pos_y, pos_z;
    logic signed [COORD_W-1:0] cx, cy, cz;
    logic signed [PROD_W-1:0]  n_prod_x, n_prod_y, n_prod_z;
    logic signed [PROD_W-1:0]  r_prod_x, r_prod_y, r_prod_z;
    logic signed [DIST_W-1:0]  d_term;
    logic signed [DIST_W-1:0]  plane_dist;

    // Positive vertex: box maximum where the normal component is above zero
    assign pos_x = !i_plane.nx[COORD_W-1] && (i_plane.nx != '0);
    assign pos_y = !i_plane.ny[COORD_W-1] && (i_plane.ny != '0);
    assign pos_z = !i_plane.nz[COORD_W-1] && (i_plane.nz != '0);

    assign cx = (i_item.box && pos_x) ? i_item.hi.x : i_item.lo.x;
    assign cy = (i_item.box && pos_y) ? i_item.hi.y : i_item.lo.y;
    assign cz = (i_item.box && pos_z) ? i_item.hi.z : i_item.lo.z;

    assign n_prod_x = i_plane.nx * cx;
    assign n_prod_y = i_plane.ny * cy;
    assign n_prod_z = i_plane.nz * cz;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_prod_x <= n_prod_x;
            r_prod_y <= n_prod_y;
            r_prod_z <= n_prod_z;
        end
    end

    // Offset scaled to the product units; the user must hold planes still while items are in flight (not enforced)
    assign d_term = {{(DIST_W-COORD_W-NORM_FRAC){i_plane.d[COORD_W-1]}},
                     i_plane.d, {NORM_FRAC{1'b0}}};

    assign plane_dist = DIST_W'(r_prod_x) + DIST_W'(r_prod_y) + DIST_W'(r_prod_z) + d_term;

    assign o_reject = plane_dist < DIST_W'(i_limit);

endmodule

// ----- src/frustum_cull_test_unit.sv -----
// Top level of the frustum cull test unit: input stage, plane evaluators, result stage.
// Registers from an input transfer to the result on the master side:
//   input register, product register, result register.
// Throughput: one item per cycle while the master side is ready; each plane has its own three multipliers.
// Reset: synchronous, active low; clears all stage valid flags and all plane
//   registers, so every object tests inside until planes are loaded.
module frustum_cull_test_unit #(
    parameter int NUM_PLANES = 6
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // Slave side
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // tdata: ax[15:0], ay[31:16], az[47:32], bx[63:48], by[79:64], bz[95:80],
    //        sphere_radius[110:96], zero[111]
    input  logic [fct_pkg::S_TDATA_W-1:0]      i_s_tdata,
    // tuser: action[0] (0 sphere, 1 box)
    input  logic                               i_s_tuser,
    // Master side
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // tdata: inside_res[0], zero[7:1]
    output logic [fct_pkg::M_TDATA_W-1:0]      o_m_tdata,
    // Configuration: index 0 left, 1 right, 2 top, 3 bottom, 4 far, 5 near
    input  logic                               i_cfg_we,
    input  logic [fct_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [fct_pkg::PLANE_W-1:0]        i_cfg_data
);
    import fct_pkg::*;

    // Planes beyond the registers are zero and never reject, so store only those tested
    localparam int NUM_STORED = (NUM_PLANES < CFG_COUNT) ? NUM_PLANES : CFG_COUNT;

    t_plane [NUM_STORED-1:0] planes;
    logic   [NUM_STORED-1:0] reject;

    // Stage enables: a stage advances when it is empty or the next one advances
    logic en_out, en_s1, en_s0;

    logic                       r_s0_valid;
    t_item                      r_s0_item;
    logic [RADIUS_W-1:0]        r_s0_radius;

    logic                       r_s1_valid;
    logic signed [LIMIT_W-1:0]  r_s1_limit;
    logic signed [LIMIT_W-1:0]  n_s1_limit;

    logic                       r_out_valid;
    logic                       r_out_inside;
    logic                       n_out_inside;

    t_item                      n_s0_item;

    assign en_out     = !r_out_valid || i_m_tready;
    assign en_s1      = !r_s1_valid || en_out;
    assign en_s0      = !r_s0_valid || en_s1;
    assign o_s_tready = en_s0;

    fct_cfg_regs #(
        .NUM_STORED (NUM_STORED)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_planes   (planes)
    );

    // Unpack the slave transfer
    assign n_s0_item.box  = i_s_tuser;
    assign n_s0_item.lo.x = i_s_tdata[15:0];
    assign n_s0_item.lo.y = i_s_tdata[31:16];
    assign n_s0_item.lo.z = i_s_tdata[47:32];
    assign n_s0_item.hi.x = i_s_tdata[63:48];
    assign n_s0_item.hi.y = i_s_tdata[79:64];
    assign n_s0_item.hi.z = i_s_tdata[95:80];

    // Input stage: hold the item on a transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_valid <= 1'b0;
        end else if (en_s0) begin
            r_s0_valid <= i_s_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s0 && i_s_tvalid) begin
            r_s0_item   <= n_s0_item;
            r_s0_radius <= i_s_tdata[110:96];
        end
    end

    // Rejection limit: zero for a box, minus the scaled radius for a sphere
    assign n_s1_limit = r_s0_item.box ? '0 :
                        -$signed({1'b0, r_s0_radius, {NORM_FRAC{1'b0}}});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (en_s1) begin
            r_s1_valid <= r_s0_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_s1) begin
            r_s1_limit <= n_s1_limit;
        end
    end

    // One evaluator per stored plane, all working on the same item
    for (genvar p = 0; p < NUM_STORED; p++) begin : g_plane
        fct_plane_eval u_eval (
            .i_clk    (i_clk),
            .i_en     (en_s1),
            .i_plane  (planes[p]),
            .i_item   (r_s0_item),
            .i_limit  (r_s1_limit),
            .o_reject (reject[p])
        );
    end

    // Inside when no plane rejects
    assign n_out_inside = !(|reject);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (en_out) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_out) begin
            r_out_inside <= n_out_inside;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(M_TDATA_W-1){1'b0}}, r_out_inside};

endmodule

// ----- src/fct_checker.sv -----
// Port-level checks of the frustum cull test unit and their binding.
module fct_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_s_tready,
    input logic                           o_m_tvalid,
    input logic                           i_m_tready,
    input logic [fct_pkg::M_TDATA_W-1:0]  o_m_tdata
);
    import fct_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    // No result can appear out of reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result valid after reset");

    // An empty result stage leaves the whole pipe free to take input
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid |-> o_s_tready)
        else $error("input stalled with empty result stage");

    // Downstream ready never stalls the input side
    a_ready_chain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tready |-> o_s_tready)
        else $error("input stalled while output drains");

    // Result padding stays zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> (o_m_tdata[M_TDATA_W-1:1] == '0))
        else $error("result padding not zero");

endmodule

bind frustum_cull_test_unit fct_checker u_fct_checker (.*);

// ----- sim/tb_frustum_cull_test_unit.sv -----
// Self-checking testbench of the frustum cull test unit: directed and random culling tests.
module tb_frustum_cull_test_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import fct_pkg::*;

    localparam int     NUM_PLANES  = 6;
    localparam int     PLANE_SLOTS = 8;               // every index the port can address
    localparam int     PIPE_LAT    = 3;               // input, product and result registers
    localparam int     HOLD_CYCLES = 200;             // long receiver hold-off
    localparam int     STALL_LIMIT = 2000;            // cycles without any transfer
    localparam longint D_SCALE     = longint'(1) << NORM_FRAC;

    // One object as offered on the slave side
    typedef struct packed {
        logic                box;
        t_vec3               lo;      // sphere centre or box minimum
        t_vec3               hi;      // box maximum
        logic [RADIUS_W-1:0] radius;
    } t_cull_obj;

    // ------------------------------------------------------------------
    // Clock, reset and the block's inputs (all known from time zero)
    // ------------------------------------------------------------------
    logic                 i_clk    = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic [S_TDATA_W-1:0] s_tdata  = '0;
    logic                 s_tuser  = 1'b0;
    logic                 m_tready = 1'b0;
    logic                 cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_idx  = '0;
    logic [PLANE_W-1:0]   cfg_data = '0;

    logic                 o_s_tready;
    logic                 o_m_tvalid;
    logic [M_TDATA_W-1:0] o_m_tdata;

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    frustum_cull_test_unit #(
        .NUM_PLANES (NUM_PLANES)
    ) uut (
        .i_clk      (i_clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (s_tdata),
        .i_s_tuser  (s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (m_tready),
        .o_m_tdata  (o_m_tdata),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    // ------------------------------------------------------------------
    // Shared state of stimulus and checking
    // ------------------------------------------------------------------
    logic [PLANE_W-1:0] plane_shadow [PLANE_SLOTS];  // planes as the block should hold them
    logic               pending_inside [$];         // inside flags still owed by the block
    int                 n_errors  = 0;
    bit                 bursty    = 1'b1;           // random gaps on both sides when set
    bit                 hold_sink = 1'b0;           // request one long receiver hold-off

    initial begin
        foreach (plane_shadow[i])
            plane_shadow[i] = '0;
    end

    // ------------------------------------------------------------------
    // Expected culling verdict for one object against the shadow planes.
    // Distances are exact in units of 2^-18: n.p + d * 2^14.
    // ------------------------------------------------------------------
    function automatic logic predict_inside(t_cull_obj obj);
        t_plane pl;
        longint limit;
        longint plane_dist;
        limit = obj.box ? longint'(0) : -(longint'(obj.radius) * D_SCALE);
        for (int p = 0; p < NUM_PLANES; p++) begin
            pl         = plane_shadow[p];
            plane_dist = longint'(pl.d) * D_SCALE;
            // box mode takes the positive vertex: maximum where the normal is above zero
            plane_dist += longint'(pl.nx) *
                          longint'((obj.box && pl.nx > 0) ? obj.hi.x : obj.lo.x);
            plane_dist += longint'(pl.ny) *
                          longint'((obj.box && pl.ny > 0) ? obj.hi.y : obj.lo.y);
            plane_dist += longint'(pl.nz) *
                          longint'((obj.box && pl.nz > 0) ? obj.hi.z : obj.lo.z);
            if (plane_dist < limit)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    // Idle length: mostly short, now and then long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 80)
            return $urandom_range(1, 3);
        if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic t_cull_obj make_obj(bit box, int ax, int ay, int az,
                                           int bx, int by, int bz, int r);
        t_cull_obj obj;
        obj.box    = box;
        obj.lo.x   = COORD_W'(ax);
        obj.lo.y   = COORD_W'(ay);
        obj.lo.z   = COORD_W'(az);
        obj.hi.x   = COORD_W'(bx);
        obj.hi.y   = COORD_W'(by);
        obj.hi.z   = COORD_W'(bz);
        obj.radius = RADIUS_W'(r);
        return obj;
    endfunction

    // Coordinate within +/- span, or any 16-bit value for the widest span
    function automatic logic signed [COORD_W-1:0] rand_coord(int span);
        if (span >= 32768)
            return COORD_W'($urandom);
        return COORD_W'(int'($urandom_range(0, 2 * span)) - span);
    endfunction

    // Random object: mostly near the origin so that verdicts mix, some over the full range
    function automatic t_cull_obj random_obj();
        t_cull_obj obj;
        int        span;
        int        r;
        r    = $urandom_range(0, 9);
        span = (r < 5) ? 2048 : (r < 8) ? 8192 : 32768;
        obj.box  = 1'($urandom_range(0, 1));
        obj.lo.x = rand_coord(span);
        obj.lo.y = rand_coord(span);
        obj.lo.z = rand_coord(span);
        if ($urandom_range(0, 9) == 0) begin
            // unrelated maximum: inverted boxes on some axes
            obj.hi = (3 * COORD_W)'({$urandom, $urandom});
        end else begin
            obj.hi.x = obj.lo.x + $signed(COORD_W'($urandom_range(0, span / 2)));
            obj.hi.y = obj.lo.y + $signed(COORD_W'($urandom_range(0, span / 2)));
            obj.hi.z = obj.lo.z + $signed(COORD_W'($urandom_range(0, span / 2)));
        end
        obj.radius = (span >= 32768) ? RADIUS_W'($urandom) : RADIUS_W'($urandom_range(0, span / 4));
        return obj;
    endfunction

    // Random plane: mostly a plausible frustum side, now and then any bit pattern
    function automatic logic [PLANE_W-1:0] random_plane();
        t_plane pl;
        if ($urandom_range(0, 3) == 0) begin
            pl = {$urandom, $urandom};
        end else begin
            pl.nx = COORD_W'(int'($urandom_range(0, 32768)) - 16384);
            pl.ny = COORD_W'(int'($urandom_range(0, 32768)) - 16384);
            pl.nz = COORD_W'(int'($urandom_range(0, 32768)) - 16384);
            pl.d  = ($urandom_range(0, 4) == 0) ? COORD_W'($urandom)
                                                : COORD_W'($urandom_range(2000, 32767));
        end
        return pl;
    endfunction

    // ------------------------------------------------------------------
    // Driver tasks
    // ------------------------------------------------------------------

    // Offer one object and return in the step of its transfer; tvalid is left
    // high so that a back-to-back object follows without a bubble.
    task automatic send_object(input t_cull_obj obj);
        int gap;
        gap = (bursty && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, obj.radius, obj.hi, obj.lo};
        s_tuser  <= obj.box;
        do
            @(posedge i_clk);
        while (!o_s_tready);
        pending_inside.push_back(predict_inside(obj));
    endtask

    // Drop tvalid, wait for every owed result, then let the pipeline run dry
    task automatic settle();
        s_tvalid <= 1'b0;
        while (pending_inside.size() != 0)
            @(posedge i_clk);
        repeat (PIPE_LAT + 2) @(posedge i_clk);
    endtask

    // Write all eight register indexes back to back; six and seven must be ignored
    task automatic load_frustum(input logic [PLANE_W-1:0] regs [PLANE_SLOTS]);
        settle();
        for (int i = 0; i < PLANE_SLOTS; i++) begin
            cfg_we   <= 1'b1;
            cfg_idx  <= CFG_IDX_W'(i);
            cfg_data <= regs[i];
            @(posedge i_clk);
            if (i < CFG_COUNT)
                plane_shadow[i] = regs[i];
        end
        cfg_we <= 1'b0;
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, stretches of constant ready, one long hold-off on request
    // ------------------------------------------------------------------
    initial begin
        wait (rst_n);
        forever begin
            @(posedge i_clk);
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_sink = 1'b0;
                m_tready <= 1'b1;
            end else if (bursty && $urandom_range(0, 99) < 25) begin
                m_tready <= 1'b0;
                repeat (idle_len()) @(posedge i_clk);
                m_tready <= 1'b1;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: each master-side transfer against the oldest expectation
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rst_n && o_m_tvalid && m_tready) begin
            if (pending_inside.size() == 0) begin
                $display("%0t: result with none expected, actual tdata %h", $time, o_m_tdata);
                n_errors++;
            end else begin
                if (o_m_tdata[0] !== pending_inside[0]) begin
                    $display("%0t: inside_res mismatch, expected %b, actual %b",
                             $time, pending_inside[0], o_m_tdata[0]);
                    n_errors++;
                end
                if (o_m_tdata[M_TDATA_W-1:1] !== '0) begin
                    $display("%0t: tdata padding mismatch, expected %h, actual %h",
                             $time, {(M_TDATA_W - 1){1'b0}}, o_m_tdata[M_TDATA_W-1:1]);
                    n_errors++;
                end
                void'(pending_inside.pop_front());
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: end the run when no transfer of any kind happens for too long
    // ------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge i_clk) begin
        if (!rst_n || cfg_we || (s_tvalid && o_s_tready) || (o_m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Planes cleared by reset never reject: every object tests inside
    task automatic test_reset_planes();
        send_object(make_obj(0, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_object(make_obj(0, 32767, 32767, 32767, -32768, -32768, -32768, 32767));
        send_object(make_obj(1, -32768, -32768, -32768, 32767, 32767, 32767, 32767));
        send_object(make_obj(1, 32767, 32767, 32767, -32768, -32768, -32768, 0));
    endtask

    // Axis-aligned cube of half size 100.0 with unit normals: touching and
    // just-beyond spheres and boxes, inverted boxes and coordinate extremes
    task automatic test_cube_frustum();
        logic [PLANE_W-1:0] regs [PLANE_SLOTS];
        regs[0] = {16'sd1600,  16'sd0,      16'sd0,      16'sd16384};   // left   x >= -100
        regs[1] = {16'sd1600,  16'sd0,      16'sd0,     -16'sd16384};   // right  x <=  100
        regs[2] = {16'sd1600,  16'sd0,     -16'sd16384,  16'sd0};       // top    y <=  100
        regs[3] = {16'sd1600,  16'sd0,      16'sd16384,  16'sd0};       // bottom y >= -100
        regs[4] = {16'sd1600, -16'sd16384,  16'sd0,      16'sd0};       // far    z <=  100
        regs[5] = {16'sd1600,  16'sd16384,  16'sd0,      16'sd0};       // near   z >= -100
        regs[6] = {4{16'h8000}};                                        // must be ignored
        regs[7] = '1;
        load_frustum(regs);
        send_object(make_obj(0, 0, 0, 0, 0, 0, 0, 0));                  // centre, no radius
        send_object(make_obj(0, -1700, 0, 0, 0, 0, 0, 100));            // touches left plane
        send_object(make_obj(0, -1700, 0, 0, 0, 0, 0, 99));             // just outside
        send_object(make_obj(0, 0, 0, 1601, 0, 0, 0, 0));               // beyond far plane
        send_object(make_obj(0, -32768, 0, 0, 0, 0, 0, 32767));         // huge sphere far left
        send_object(make_obj(0, 32767, 0, 0, 0, 0, 0, 32767));          // huge sphere far right
        send_object(make_obj(0, 32767, -32768, 32767, 0, 0, 0, 0));     // corner extremes
        send_object(make_obj(1, -1700, -10, -10, -1600, 10, 10, 0));    // box face on left plane
        send_object(make_obj(1, -1700, -10, -10, -1601, 10, 10, 0));    // box just outside
        send_object(make_obj(1, 100, 100, 100, -100, -100, -100, 0));   // inverted, vertex inside
        send_object(make_obj(1, 1700, 0, 0, -1700, 0, 0, 0));           // inverted, rejected
        send_object(make_obj(1, -32768, -32768, -32768, 32767, 32767, 32767, 0));
        send_object(make_obj(1, 32767, 32767, 32767, 32767, 32767, 32767, 32767));
        send_object(make_obj(1, 0, 0, -1601, 0, 0, -1601, 0));          // behind near plane
    endtask

    // Several plane settings, extremes first, each followed by random objects
    task automatic test_random_frustums();
        logic [PLANE_W-1:0] regs [PLANE_SLOTS];
        for (int ph = 0; ph < 8; ph++) begin
            for (int i = 0; i < PLANE_SLOTS; i++) begin
                case (ph)
                    0:       regs[i] = {4{16'h7fff}};   // largest positive fields
                    1:       regs[i] = {4{16'h8000}};   // most negative fields
                    2:       regs[i] = '1;
                    default: regs[i] = random_plane();
                endcase
            end
            bursty = (ph != 5);                          // one phase at full rate
            load_frustum(regs);
            repeat (125) send_object(random_obj());
        end
        bursty = 1'b1;
    endtask

    // Hold the receiver off while objects keep coming, so the pipeline fills
    // and the slave side has to stall
    task automatic test_backpressure();
        settle();
        bursty    = 1'b0;
        hold_sink = 1'b1;
        repeat (40) send_object(random_obj());
        bursty = 1'b1;
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_planes();
        test_cube_frustum();
        test_random_frustums();
        test_backpressure();
        settle();
        if (n_errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

// ----- filelist.f -----
src/fct_pkg.sv
src/fct_cfg_regs.sv
src/fct_plane_eval.sv
src/frustum_cull_test_unit.sv
src/fct_checker.sv
sim/tb_frustum_cull_test_unit.sv
